// ===== rtl/core/flsa_pkg.sv =====
// ----------------------------------------------------------------------------
// flsa_pkg
// Shared types and constants of the free-list slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package flsa_pkg;

  localparam int POOL_DEPTH_DEF = 256;

  localparam int OP_W     = 2;
  localparam int SLOT_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CAP_W    = 9;
  localparam int MISS_W   = 32;

  // slots reachable through an index field
  localparam int SLOT_SPAN = 2 ** SLOT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_INIT  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_REJECTED  = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/flsa_ram.sv =====
// ----------------------------------------------------------------------------
// flsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module flsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/free_list_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_slot_allocator
// LIFO free-list allocator: link and busy flag of every slot in one RAM.
// ----------------------------------------------------------------------------
// Alloc and free: result registered in S_EXEC; the unused op: in S_FIN. A
// stalled result holds all, and no new request is taken until the block is
// back in S_IDLE, after the RAM read and write-back. Init: S_SWEEP writes one
// RAM entry per cycle, min(POOL_DEPTH, 256) in all, then S_FIN gives the result.
// Reset (synchronous): free list empty, counters zero, capacity 256; the RAM
// is not cleared, so an init must come before the first free.
// ----------------------------------------------------------------------------
`default_nettype none

module free_list_slot_allocator #(
  parameter int POOL_DEPTH = flsa_pkg::POOL_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [flsa_pkg::OP_W-1:0]      op,
  input  logic [flsa_pkg::SLOT_W-1:0]    slot_index,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [flsa_pkg::STATUS_W-1:0]  status,
  output logic [flsa_pkg::SLOT_W-1:0]    granted_index,
  output logic [flsa_pkg::CAP_W-1:0]     in_use_total,
  output logic [flsa_pkg::MISS_W-1:0]    miss_total,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [flsa_pkg::CAP_W-1:0]     pool_capacity
);

  import flsa_pkg::*;

  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int LINK_W     = $clog2(POOL_DEPTH + 1);
  localparam int ENT_W      = LINK_W + 1;
  localparam int SLOT_LIMIT = (POOL_DEPTH < SLOT_SPAN) ? POOL_DEPTH : SLOT_SPAN;
  localparam int SWP_W      = $clog2(SLOT_LIMIT);

  localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(POOL_DEPTH);
  localparam logic [CAP_W-1:0]  CAP_LIMIT = CAP_W'(SLOT_LIMIT);
  localparam logic [SWP_W-1:0]  SWP_LAST  = SWP_W'(SLOT_LIMIT - 1);
  localparam logic [MISS_W-1:0] MISS_MAX  = '1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_SWEEP = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t             state;
  op_t                req_op;
  logic [SLOT_W-1:0]  req_slot;
  logic [LINK_W-1:0]  head;
  logic [CAP_W-1:0]   busy_count;
  logic [MISS_W-1:0]  miss_count;
  logic [CAP_W-1:0]   capacity;
  logic [CAP_W-1:0]   cap_eff;
  logic [SWP_W-1:0]   sweep_idx;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENT_W-1:0]   ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENT_W-1:0]   ram_rdata;

  logic               rd_busy;
  logic [LINK_W-1:0]  rd_link;
  logic               head_valid;
  logic               slot_in_range;
  logic               free_ok;
  logic               out_free;
  logic               exec_go;
  logic               result_load;
  logic [LINK_W-1:0]  sweep_link;
  op_t                in_op;

  status_t            status_next;
  logic [SLOT_W-1:0]  granted_next;
  logic [LINK_W-1:0]  head_next;
  logic [CAP_W-1:0]   busy_next;
  logic [MISS_W-1:0]  miss_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_op     = op_t'(op);

  assign rd_busy       = ram_rdata[LINK_W];
  assign rd_link       = ram_rdata[LINK_W-1:0];
  assign head_valid    = (head != NO_LINK);
  assign slot_in_range = (32'(req_slot) < 32'(POOL_DEPTH));
  assign free_ok       = slot_in_range && rd_busy;
  assign out_free      = !out_valid || out_ready;
  assign exec_go       = (state == S_EXEC) && out_free;
  assign result_load   = ((state == S_EXEC) || (state == S_FIN)) && out_free;

  // read the head entry for alloc, the returned slot for free
  assign ram_re    = in_valid && in_ready && (in_op == OP_ALLOC || in_op == OP_FREE);
  assign ram_raddr = (in_op == OP_ALLOC) ? head[IDX_W-1:0] : IDX_W'(slot_index);

  // init chain: slot i below the capacity links to i-1; slot 0 and the rest end the list
  assign sweep_link = (sweep_idx != '0 && CAP_W'(sweep_idx) < cap_eff)
                      ? LINK_W'(sweep_idx - 1'b1) : NO_LINK;

  always_comb begin
    status_next  = ST_OK;
    granted_next = '0;
    head_next    = head;
    busy_next    = busy_count;
    miss_next    = miss_count;
    unique case (req_op)
      OP_ALLOC: begin
        if (head_valid) begin
          granted_next = SLOT_W'(head);
          head_next    = rd_link;
          busy_next    = busy_count + 1'b1;
        end else begin
          status_next = ST_EXHAUSTED;
          if (miss_count != MISS_MAX) begin
            miss_next = miss_count + 1'b1;
          end
        end
      end
      OP_FREE: begin
        if (free_ok) begin
          head_next = LINK_W'(req_slot);
          if (busy_count != '0) begin
            busy_next = busy_count - 1'b1;
          end
        end else begin
          status_next = ST_REJECTED;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (state == S_SWEEP) begin
      ram_we    = 1'b1;
      ram_waddr = IDX_W'(sweep_idx);
      ram_wdata = {1'b0, sweep_link};
    end else if (exec_go) begin
      if (req_op == OP_ALLOC && head_valid) begin
        ram_we    = 1'b1;
        ram_waddr = head[IDX_W-1:0];
        ram_wdata = {1'b1, NO_LINK};
      end else if (req_op == OP_FREE && free_ok) begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(req_slot);
        ram_wdata = {1'b0, head};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= NO_LINK;
      busy_count <= '0;
      miss_count <= '0;
      capacity   <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        capacity <= pool_capacity;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_op   <= in_op;
            req_slot <= slot_index;
            unique case (in_op)
              OP_ALLOC, OP_FREE: state <= S_EXEC;
              OP_INIT: begin
                sweep_idx <= '0;
                cap_eff   <= (capacity > CAP_LIMIT) ? CAP_LIMIT : capacity;
                state     <= S_SWEEP;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_EXEC: begin
          if (out_free) begin
            head          <= head_next;
            busy_count    <= busy_next;
            miss_count    <= miss_next;
            status        <= status_next;
            granted_index <= granted_next;
            in_use_total  <= busy_next;
            miss_total    <= miss_next;
            state         <= S_IDLE;
          end
        end
        S_SWEEP: begin
          sweep_idx <= sweep_idx + 1'b1;
          if (sweep_idx == SWP_LAST) begin
            head       <= (cap_eff == '0) ? NO_LINK : LINK_W'(cap_eff - 1'b1);
            busy_count <= '0;
            miss_count <= '0;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            status        <= ST_OK;
            granted_index <= '0;
            in_use_total  <= busy_count;
            miss_total    <= miss_count;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  flsa_ram #(
    .WIDTH (ENT_W),
    .DEPTH (POOL_DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/core/flsa_checker.sv =====
// ----------------------------------------------------------------------------
// flsa_checker
// Port-level checks on the free-list slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module flsa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [flsa_pkg::STATUS_W-1:0] status,
  input logic [flsa_pkg::SLOT_W-1:0]   granted_index,
  input logic [flsa_pkg::CAP_W-1:0]    in_use_total,
  input logic [flsa_pkg::MISS_W-1:0]   miss_total
);

  import flsa_pkg::*;

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still valid after reset");

  // one request at a time: no second request on the next edge
  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

  a_refused_no_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EXHAUSTED || status == ST_REJECTED)
      |-> granted_index == '0)
    else $error("refused request reports a granted slot");

  a_miss_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EXHAUSTED |-> miss_total != '0)
    else $error("exhausted alloc not counted");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted_index)
      && $stable(in_use_total) && $stable(miss_total))
    else $error("stalled result changed");

endmodule

bind free_list_slot_allocator flsa_checker u_flsa_checker (.*);

`default_nettype wire

// ===== dv/tb_free_list_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_free_list_slot_allocator
// Self-checking bench for the LIFO free-list slot allocator: a directed table
// of requests and capacity writes, then random phases of alloc/free traffic
// with an init per phase, checked against typed rows or an in-bench pool copy.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_free_list_slot_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import flsa_pkg::*;

  localparam int DEPTH        = POOL_DEPTH_DEF;
  localparam int SLOT_CAP     = (DEPTH < 256) ? DEPTH : 256;
  localparam int NO_LINK      = DEPTH;
  localparam int ITEMS_TARGET = 1750;
  localparam int CALM_TAIL    = 250;
  localparam int DRAIN_CYCLES = SLOT_CAP + 40;
  localparam int SETTLE_LIMIT = 20000;
  localparam int DIR_N        = 26;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    status_t          status;
    logic [SLOT_W-1:0] granted;
    logic [CAP_W-1:0]  in_use;
    logic [MISS_W-1:0] misses;
  } slot_reply_t;

  typedef enum logic {ROW_CAP, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    op_t               opc;
    logic [SLOT_W-1:0] slot;
    logic [CAP_W-1:0]  cap;
    bit                typed;
    slot_reply_t       want;
  } dir_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     op;
  logic [SLOT_W-1:0]   slot_index;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   granted_index;
  logic [CAP_W-1:0]    in_use_total;
  logic [MISS_W-1:0]   miss_total;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CAP_W-1:0]    pool_capacity;

  free_list_slot_allocator #(.POOL_DEPTH(DEPTH)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .slot_index   (slot_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .granted_index(granted_index),
    .in_use_total (in_use_total),
    .miss_total   (miss_total),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .pool_capacity(pool_capacity)
  );

  // Bench copy of the pool
  logic [CAP_W-1:0]  link_of [DEPTH];
  bit                busy_flag [DEPTH];
  logic [CAP_W-1:0]  head_slot;
  logic [CAP_W-1:0]  busy_n;
  logic [MISS_W-1:0] miss_n;
  logic [CAP_W-1:0]  cap_reg;

  slot_reply_t replies_due[$];

  bit idle_en;
  bit stall_en;
  int sent_n;
  int cap_writes;
  int grant_n;
  int exhaust_n;
  int reject_n;
  int mismatch_n;
  int stray_n;

  function automatic slot_reply_t step_pool(op_t o, logic [SLOT_W-1:0] s);
    slot_reply_t r;
    int lim;
    r = '{ST_OK, '0, '0, '0};
    case (o)
      OP_ALLOC: begin
        if (head_slot < NO_LINK) begin
          r.granted = head_slot[SLOT_W-1:0];
          busy_flag[head_slot] = 1'b1;
          // take the successor before the link is overwritten
          head_slot = link_of[r.granted];
          link_of[r.granted] = CAP_W'(NO_LINK);
          busy_n++;
        end else begin
          r.status = ST_EXHAUSTED;
          if (miss_n != '1) miss_n++;
        end
      end
      OP_FREE: begin
        if (int'(s) < DEPTH && busy_flag[s]) begin
          busy_flag[s] = 1'b0;
          link_of[s] = head_slot;
          head_slot = CAP_W'(s);
          if (busy_n != 0) busy_n--;
        end else begin
          r.status = ST_REJECTED;
        end
      end
      OP_INIT: begin
        lim = (int'(cap_reg) > SLOT_CAP) ? SLOT_CAP : int'(cap_reg);
        foreach (busy_flag[i]) busy_flag[i] = 1'b0;
        head_slot = CAP_W'(NO_LINK);
        for (int i = 0; i < lim; i++) begin
          link_of[i] = head_slot;
          head_slot = CAP_W'(i);
        end
        busy_n = '0;
        miss_n = '0;
      end
      default: ;
    endcase
    r.in_use = busy_n;
    r.misses = miss_n;
    return r;
  endfunction

  dir_row_t dir_rows [DIR_N] = '{
    // alloc before any init, unused op, then a full-pool init
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_EXHAUSTED, 8'd0,   9'd0, 32'd1}},
    '{ROW_REQ, OP_NONE,  8'hFF, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd1}},
    '{ROW_REQ, OP_INIT,  8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_OK,        8'd255, 9'd1, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_OK,        8'd254, 9'd2, 32'd0}},
    '{ROW_REQ, OP_FREE,  8'hFF, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd1, 32'd0}},
    '{ROW_REQ, OP_FREE,  8'hFF, 9'd0,   1'b1, '{ST_REJECTED,  8'd0,   9'd1, 32'd0}},
    '{ROW_REQ, OP_FREE,  8'h00, 9'd0,   1'b1, '{ST_REJECTED,  8'd0,   9'd1, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_OK,        8'd255, 9'd2, 32'd0}},
    '{ROW_REQ, OP_FREE,  8'hFE, 9'd0,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    // single-slot pool
    '{ROW_CAP, OP_NONE,  8'h00, 9'd1,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_INIT,  8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd1, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_EXHAUSTED, 8'd0,   9'd1, 32'd1}},
    '{ROW_REQ, OP_FREE,  8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd1}},
    '{ROW_REQ, OP_NONE,  8'h00, 9'd0,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    // empty pool after init
    '{ROW_CAP, OP_NONE,  8'h00, 9'd0,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_INIT,  8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_EXHAUSTED, 8'd0,   9'd0, 32'd1}},
    '{ROW_REQ, OP_FREE,  8'hAA, 9'd0,   1'b1, '{ST_REJECTED,  8'd0,   9'd0, 32'd1}},
    // capacity above the pool saturates
    '{ROW_CAP, OP_NONE,  8'h00, 9'd511, 1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_INIT,  8'h00, 9'd0,   1'b1, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h00, 9'd0,   1'b1, '{ST_OK,        8'd255, 9'd1, 32'd0}},
    '{ROW_REQ, OP_ALLOC, 8'h55, 9'd0,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_CAP, OP_NONE,  8'h00, 9'd256, 1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}},
    '{ROW_REQ, OP_INIT,  8'h00, 9'd0,   1'b0, '{ST_OK,        8'd0,   9'd0, 32'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Issue one request; returns in the time step of its acceptance edge.
  task automatic send_request(op_t o, logic [SLOT_W-1:0] s, bit typed, slot_reply_t want);
    slot_reply_t r;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    op         <= o;
    slot_index <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = step_pool(o, s);
    if (typed) r = want;
    replies_due = {replies_due, r};
    sent_n++;
  endtask

  // Capacity writes only with the pool quiet and every reply collected.
  task automatic write_capacity(logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    cfg_valid     <= 1'b1;
    pool_capacity <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = v;
    cap_writes++;
    cfg_valid <= 1'b0;
  endtask

  // Receiver: ready with occasional stall bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    slot_reply_t w;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        stray_n++;
        if (stray_n + mismatch_n <= MAX_REPORTS)
          $display("[%0t] reply with nothing outstanding: st=%0d g=%0d u=%0d m=%0d",
                   $time, status, granted_index, in_use_total, miss_total);
      end else begin
        w = replies_due.pop_front();
        case (status_t'(status))
          ST_EXHAUSTED: exhaust_n++;
          ST_REJECTED:  reject_n++;
          default:      grant_n++;
        endcase
        if (status !== w.status || granted_index !== w.granted ||
            in_use_total !== w.in_use || miss_total !== w.misses) begin
          mismatch_n++;
          if (stray_n + mismatch_n <= MAX_REPORTS)
            $display("[%0t] mismatch: exp st=%0d g=%0d u=%0d m=%0d, got st=%0d g=%0d u=%0d m=%0d",
                     $time, w.status, w.granted, w.in_use, w.misses,
                     status, granted_index, in_use_total, miss_total);
        end
      end
    end
  end

  initial begin : stimulus
    slot_reply_t none_r;
    logic [SLOT_W-1:0] probe;
    int phase_len;
    int pick;
    int waited;
    int leftover;
    none_r        = '{ST_OK, '0, '0, '0};
    rst           = 1'b1;
    in_valid      = 1'b0;
    op            = OP_ALLOC;
    slot_index    = '0;
    cfg_valid     = 1'b0;
    pool_capacity = CAP_RESET;
    idle_en       = 1'b1;
    stall_en      = 1'b1;
    head_slot     = CAP_W'(NO_LINK);
    busy_n        = '0;
    miss_n        = '0;
    cap_reg       = CAP_RESET;
    foreach (busy_flag[i]) begin
      busy_flag[i] = 1'b0;
      link_of[i]   = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAP)
        write_capacity(dir_rows[i].cap);
      else
        send_request(dir_rows[i].opc, dir_rows[i].slot, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases: new capacity, init, then mostly well-formed traffic
    while (sent_n < ITEMS_TARGET) begin
      if (sent_n >= ITEMS_TARGET - CALM_TAIL) begin
        idle_en  = 1'b0;
        stall_en = 1'b0;
      end else begin
        idle_en  = ($urandom_range(0, 3) != 0);
        stall_en = ($urandom_range(0, 3) != 0);
      end
      case ($urandom_range(0, 11))
        0:       write_capacity(9'd0);
        1:       write_capacity(9'd1);
        2:       write_capacity(9'd256);
        3:       write_capacity(CAP_W'($urandom_range(257, 511)));
        4, 5:    write_capacity(CAP_W'($urandom_range(1, 256)));
        default: write_capacity(CAP_W'($urandom_range(2, 24)));
      endcase
      send_request(OP_INIT, SLOT_W'($urandom_range(0, 255)), 1'b0, none_r);
      phase_len = $urandom_range(30, 90);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 46) begin
          send_request(OP_ALLOC, SLOT_W'($urandom_range(0, 255)), 1'b0, none_r);
        end else if (pick < 84) begin
          // return a slot that is really out, searching from a random start
          probe = SLOT_W'($urandom_range(0, 255));
          repeat (DEPTH) begin
            if (busy_flag[probe]) break;
            probe++;
          end
          send_request(OP_FREE, probe, 1'b0, none_r);
        end else if (pick < 94) begin
          send_request(OP_FREE, SLOT_W'($urandom_range(0, 255)), 1'b0, none_r);
        end else if (pick < 98) begin
          send_request(OP_NONE, SLOT_W'($urandom_range(0, 255)), 1'b0, none_r);
        end else begin
          send_request(OP_INIT, SLOT_W'($urandom_range(0, 255)), 1'b0, none_r);
        end
      end
    end

    in_valid <= 1'b0;
    waited = 0;
    while (replies_due.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    leftover = replies_due.size();
    if (leftover != 0)
      $display("%0d replies never arrived", leftover);

    $display("Sent %0d requests over %0d capacity settings (including 0, 1, 256, >256).",
             sent_n, cap_writes);
    $display("Replies: %0d ok, %0d exhausted, %0d rejected; %0d mismatches, %0d stray.",
             grant_n, exhaust_n, reject_n, mismatch_n, stray_n);
    if (mismatch_n == 0 && stray_n == 0 && leftover == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d replies outstanding", replies_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/flsa_pkg.sv
rtl/core/flsa_ram.sv
rtl/core/free_list_slot_allocator.sv
rtl/core/flsa_checker.sv
dv/tb_free_list_slot_allocator.sv
